>>> rtl/core/igp_pkg.sv
// igp_pkg: shared widths and defaults for the interval grid predictor
`timescale 1ns / 1ps
package igp_pkg;
	localparam int DataW = 64;
	localparam int DevW = 32;
	localparam int CfgW = 32;
	localparam int WindowDepthDef = 8;
	typedef logic [DataW-1:0] word_t;
endpackage

>>> rtl/core/interval_grid_predictor.sv
// interval_grid_predictor: top level, sequencer, interval ring and output register
//
// usage:
// - slave stream takes one mark transaction: tdata = mark_time, current_time
// - master stream returns one result transaction per mark: mean, deviation,
//   predicted tick and marks seen in tdata, history_empty and zero_step in tuser
// - apb port holds prediction_margin at address 0; write it only while idle
// - one mark runs the window sum, the mean division, the squared deviations,
//   the variance division and square root, the grid prediction and the load
//   of the result, paced by the shared bit-serial divider and multiplier; the
//   next mark can be taken in the same cycle that m_tvalid rises
// - s_tready is high only while the sequencer is idle
// - a finished result sits in the output register; the next mark is taken
//   while it waits, and its result holds until m_tready frees the register
// - reset clears counters, the previous mark and stored statistics; ring
//   entries are only read after being written
`timescale 1ns / 1ps
module interval_grid_predictor #(
	parameter int WINDOW_DEPTH = igp_pkg::WindowDepthDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [127:0]   s_tdata,   // mark_time, current_time
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [191:0]   m_tdata,   // mean_interval, interval_deviation, predicted_tick, marks_seen
	output logic [1:0]     m_tuser,   // history_empty, zero_step
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import igp_pkg::*;
	localparam int SlotW = $clog2(WINDOW_DEPTH);
	localparam int CntW = $clog2(WINDOW_DEPTH + 1);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_SUM_RD = 5'd1;
	localparam logic [4:0] S_SUM_ACC = 5'd2;
	localparam logic [4:0] S_MEAN_GO = 5'd3;
	localparam logic [4:0] S_MEAN_WAIT = 5'd4;
	localparam logic [4:0] S_VAR_RD = 5'd5;
	localparam logic [4:0] S_VAR_GO = 5'd6;
	localparam logic [4:0] S_VAR_WAIT = 5'd7;
	localparam logic [4:0] S_VD_GO = 5'd8;
	localparam logic [4:0] S_VD_WAIT = 5'd9;
	localparam logic [4:0] S_SQ_GO = 5'd10;
	localparam logic [4:0] S_SQ_WAIT = 5'd11;
	localparam logic [4:0] S_PRED = 5'd12;
	localparam logic [4:0] S_K_WAIT = 5'd13;
	localparam logic [4:0] S_KM_GO = 5'd14;
	localparam logic [4:0] S_KM_WAIT = 5'd15;
	localparam logic [4:0] S_FIN = 5'd16;

	logic [4:0] state_q;
	logic [SlotW-1:0] slot_q;
	logic [CntW-1:0] filled_q, idx_q;
	word_t prev_q, mark_q, now_q, acc_q, mean_q, base_q, rd_q;
	logic [DevW-1:0] dev_q, marks_q;
	logic [CfgW-1:0] margin_q;
	logic zstep_q;
	word_t ring [WINDOW_DEPTH];

	logic in_acc, ring_wr, last_idx;
	word_t div_num, div_den, div_quo, mul_a, mul_b, mul_prod, diff;
	logic div_start, div_done, mul_start, mul_done, sq_start, sq_done;
	logic [DevW-1:0] sq_root;

	assign in_acc = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign ring_wr = in_acc && (prev_q != '0);
	assign last_idx = (idx_q == filled_q - 1'b1);
	assign diff = rd_q - mean_q;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? '0 : margin_q;

	always_ff @(posedge clk) begin
		if (ring_wr)
			ring[slot_q] <= s_tdata[63:0] - prev_q;
		rd_q <= ring[idx_q[SlotW-1:0]];
	end

	always_comb begin
		div_start = 1'b0;
		div_num = acc_q;
		div_den = {{(DataW-CntW){1'b0}}, filled_q};
		mul_start = 1'b0;
		mul_a = diff;
		mul_b = diff;
		sq_start = (state_q == S_SQ_GO);
		case (state_q)
			S_MEAN_GO: div_start = 1'b1;
			S_VD_GO: begin
				div_start = 1'b1;
				div_den = {{(DataW-CntW){1'b0}}, filled_q - 1'b1};
			end
			S_PRED: begin
				div_start = (filled_q != '0) && (mean_q != '0) && (mark_q <= now_q);
				div_num = now_q - mark_q;
				div_den = mean_q;
			end
			S_VAR_GO: mul_start = 1'b1;
			S_KM_GO: begin
				mul_start = 1'b1;
				mul_a = div_quo + 1'b1;
				mul_b = mean_q;
			end
			default: ;
		endcase
	end

	igp_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.quo(div_quo), .done(div_done)
	);

	igp_multiplier u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.prod(mul_prod), .done(mul_done)
	);

	igp_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .x(div_quo),
		.root(sq_root), .done(sq_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slot_q <= '0;
			filled_q <= '0;
			idx_q <= '0;
			prev_q <= '0;
			mean_q <= '0;
			dev_q <= '0;
			marks_q <= '0;
			margin_q <= '0;
			m_tvalid <= 1'b0;
			zstep_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && !paddr[2])
				margin_q <= pwdata;
			if (m_tvalid && m_tready && (state_q != S_FIN))
				m_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						prev_q <= s_tdata[63:0];
						marks_q <= marks_q + 1'b1;
						idx_q <= '0;
						zstep_q <= 1'b0;
						if (ring_wr) begin
							slot_q <= (slot_q == SlotW'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
							if (filled_q != CntW'(WINDOW_DEPTH))
								filled_q <= filled_q + 1'b1;
							state_q <= S_SUM_RD;
						end else begin
							state_q <= S_PRED;
						end
					end
				end
				S_SUM_RD: state_q <= S_SUM_ACC;
				S_SUM_ACC: begin
					idx_q <= last_idx ? '0 : idx_q + 1'b1;
					state_q <= last_idx ? S_MEAN_GO : S_SUM_RD;
				end
				S_MEAN_GO: state_q <= S_MEAN_WAIT;
				S_MEAN_WAIT: begin
					if (div_done) begin
						mean_q <= div_quo;
						state_q <= (filled_q > CntW'(1)) ? S_VAR_RD : S_PRED;
					end
				end
				S_VAR_RD: state_q <= S_VAR_GO;
				S_VAR_GO: state_q <= S_VAR_WAIT;
				S_VAR_WAIT: begin
					if (mul_done) begin
						idx_q <= last_idx ? '0 : idx_q + 1'b1;
						state_q <= last_idx ? S_VD_GO : S_VAR_RD;
					end
				end
				S_VD_GO: state_q <= S_VD_WAIT;
				S_VD_WAIT: if (div_done) state_q <= S_SQ_GO;
				S_SQ_GO: state_q <= S_SQ_WAIT;
				S_SQ_WAIT: begin
					if (sq_done) begin
						dev_q <= sq_root;
						state_q <= S_PRED;
					end
				end
				S_PRED: begin
					if (filled_q == '0)
						state_q <= S_FIN;
					else if (mean_q == '0) begin
						zstep_q <= 1'b1;
						state_q <= S_FIN;
					end else if (mark_q <= now_q)
						state_q <= S_K_WAIT;
					else
						state_q <= S_FIN;
				end
				S_K_WAIT: if (div_done) state_q <= S_KM_GO;
				S_KM_GO: state_q <= S_KM_WAIT;
				S_KM_WAIT: if (mul_done) state_q <= S_FIN;
				S_FIN: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mark_q <= s_tdata[63:0];
			now_q <= s_tdata[127:64];
			acc_q <= '0;
		end else if (state_q == S_SUM_ACC) begin
			acc_q <= acc_q + rd_q;
		end else if (state_q == S_MEAN_WAIT) begin
			acc_q <= '0;
		end else if (state_q == S_VAR_WAIT && mul_done) begin
			acc_q <= acc_q + mul_prod;
		end
		if (state_q == S_PRED)
			base_q <= (filled_q == '0) ? '0 : mark_q;
		else if (state_q == S_KM_WAIT && mul_done)
			base_q <= mark_q + mul_prod;
		if (state_q == S_FIN && (!m_tvalid || m_tready)) begin
			m_tdata <= {marks_q, base_q + {{(DataW-CfgW){1'b0}}, margin_q}, dev_q, mean_q};
			m_tuser <= {zstep_q, filled_q == '0};
		end
	end

`ifndef SYNTHESIS
	a_filled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= CntW'(WINDOW_DEPTH))
		else $error("filled count above window depth");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_zstep_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("zero step flagged with empty history");
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("accepted while busy");
`endif
endmodule

>>> rtl/core/igp_divider.sv
// igp_divider: restoring 64-bit unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
module igp_divider (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  igp_pkg::word_t num,
	input  igp_pkg::word_t den,
	output igp_pkg::word_t quo,
	output logic           done
);
	import igp_pkg::*;
	localparam int CntW = $clog2(DataW + 1);

	word_t rem_q, quo_q, den_q;
	logic [CntW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [DataW:0] trial;

	assign trial = {rem_q, quo_q[DataW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(DataW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DataW]) begin
				rem_q <= trial[DataW-1:0];
				quo_q <= {quo_q[DataW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DataW-2:0], quo_q[DataW-1]};
				quo_q <= {quo_q[DataW-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
	assign done = done_q;
endmodule

>>> rtl/core/igp_multiplier.sv
// igp_multiplier: shift-add multiplier, low 64 product bits, two bits per cycle
`timescale 1ns / 1ps
module igp_multiplier (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  igp_pkg::word_t a,
	input  igp_pkg::word_t b,
	output igp_pkg::word_t prod,
	output logic           done
);
	import igp_pkg::*;
	localparam int Steps = DataW / 2;
	localparam int CntW = $clog2(Steps + 1);

	word_t a_q, b_q, p_q, pp;
	logic [CntW-1:0] cnt_q;
	logic busy_q, done_q;

	always_comb begin
		case (b_q[1:0])
			2'd0: pp = '0;
			2'd1: pp = a_q;
			2'd2: pp = {a_q[DataW-2:0], 1'b0};
			2'd3: pp = a_q + {a_q[DataW-2:0], 1'b0};
			default: pp = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(Steps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (busy_q) begin
			p_q <= p_q + pp;
			a_q <= {a_q[DataW-3:0], 2'b00};
			b_q <= {2'b00, b_q[DataW-1:2]};
		end
	end

	assign prod = p_q;
	assign done = done_q;
endmodule

>>> rtl/core/igp_isqrt.sv
// igp_isqrt: digit-by-digit integer square root of a 64-bit value
`timescale 1ns / 1ps
module igp_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  igp_pkg::word_t             x,
	output logic [igp_pkg::DevW-1:0]   root,
	output logic                       done
);
	import igp_pkg::*;
	localparam int Steps = DataW / 2;
	localparam int CntW = $clog2(Steps + 1);

	word_t x_q, res_q, bit_q, trial;
	logic [CntW-1:0] cnt_q;
	logic busy_q, done_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(Steps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			res_q <= '0;
			bit_q <= {2'b01, {(DataW-2){1'b0}}};
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q <= x_q - trial;
				res_q <= {1'b0, res_q[DataW-1:1]} + bit_q;
			end else begin
				res_q <= {1'b0, res_q[DataW-1:1]};
			end
			bit_q <= {2'b00, bit_q[DataW-1:2]};
		end
	end

	assign root = res_q[DevW-1:0];
	assign done = done_q;
endmodule

>>> sim/interval_grid_predictor_checker.sv
// interval_grid_predictor_checker: predicts and checks result transactions of the grid predictor
`timescale 1ns / 1ps
module interval_grid_predictor_checker #(
	parameter int WINDOW_DEPTH = igp_pkg::WindowDepthDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [191:0] m_tdata,
	input  logic [1:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           fail_count,
	output int           pending
);
	import igp_pkg::*;

	localparam logic [2:0] AddrMargin = 3'd0;

	typedef struct packed {
		logic         zero_step;
		logic         history_empty;
		logic [31:0]  marks_seen;
		logic [63:0]  predicted_tick;
		logic [31:0]  interval_deviation;
		logic [63:0]  mean_interval;
	} grid_result_t;

	word_t        ring [WINDOW_DEPTH];
	int unsigned  slot;
	int unsigned  filled;
	word_t        prev_mark;
	word_t        mean_q;
	logic [31:0]  dev_q;
	logic [31:0]  mark_cnt;
	logic [31:0]  margin;
	grid_result_t expected_results [$];

	assign pending = expected_results.size();

	function automatic logic [31:0] floor_sqrt(word_t x);
		word_t res;
		word_t b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res[31:0];
	endfunction

	task automatic predict_grid(word_t mark, word_t now);
		grid_result_t r;
		word_t sum;
		word_t m2;
		word_t d;
		word_t tick;
		word_t k;
		sum = 0;
		m2 = 0;
		tick = 0;
		r = '0;
		if (prev_mark != 0) begin
			ring[slot] = mark - prev_mark;
			slot = (slot + 1) % WINDOW_DEPTH;
			if (filled < WINDOW_DEPTH)
				filled++;
			for (int i = 0; i < filled; i++)
				sum += ring[i];
			mean_q = sum / word_t'(filled);
			if (filled > 1) begin
				for (int i = 0; i < filled; i++) begin
					d = ring[i] - mean_q;
					m2 += d * d;
				end
				dev_q = floor_sqrt(m2 / word_t'(filled - 1));
			end
		end
		prev_mark = mark;
		mark_cnt++;
		r.history_empty = (filled == 0);
		if (filled != 0) begin
			tick = mark;
			if (mean_q == 0) begin
				r.zero_step = 1'b1;
			end else if (tick <= now) begin
				k = (now - tick) / mean_q + 1;
				tick = tick + k * mean_q;
			end
		end
		r.predicted_tick = tick + word_t'(margin);
		r.mean_interval = mean_q;
		r.interval_deviation = dev_q;
		r.marks_seen = mark_cnt;
		expected_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		grid_result_t e;
		grid_result_t a;
		if (!arst_n) begin
			slot = 0;
			filled = 0;
			prev_mark = 0;
			mean_q = 0;
			dev_q = 0;
			mark_cnt = 0;
			margin = 0;
			fail_count = 0;
			expected_results.delete();
			for (int i = 0; i < WINDOW_DEPTH; i++)
				ring[i] = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				a.mean_interval = m_tdata[63:0];
				a.interval_deviation = m_tdata[95:64];
				a.predicted_tick = m_tdata[159:96];
				a.marks_seen = m_tdata[191:160];
				a.history_empty = m_tuser[0];
				a.zero_step = m_tuser[1];
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction");
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					if (a.mean_interval !== e.mean_interval) begin
						$error("mean_interval exp %0d got %0d", e.mean_interval,
							a.mean_interval);
						fail_count++;
					end
					if (a.interval_deviation !== e.interval_deviation) begin
						$error("interval_deviation exp %0d got %0d",
							e.interval_deviation, a.interval_deviation);
						fail_count++;
					end
					if (a.predicted_tick !== e.predicted_tick) begin
						$error("predicted_tick exp %0d got %0d", e.predicted_tick,
							a.predicted_tick);
						fail_count++;
					end
					if (a.marks_seen !== e.marks_seen) begin
						$error("marks_seen exp %0d got %0d", e.marks_seen, a.marks_seen);
						fail_count++;
					end
					if (a.history_empty !== e.history_empty) begin
						$error("history_empty exp %0b got %0b", e.history_empty,
							a.history_empty);
						fail_count++;
					end
					if (a.zero_step !== e.zero_step) begin
						$error("zero_step exp %0b got %0b", e.zero_step, a.zero_step);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_grid(s_tdata[63:0], s_tdata[127:64]);
			if (psel && penable && pwrite && pready && paddr == AddrMargin)
				margin = pwdata;
		end
	end
endmodule

>>> sim/interval_grid_predictor_tb.sv
// interval_grid_predictor_tb: stimulus, reset and verdict for the interval grid predictor
`timescale 1ns / 1ps
module interval_grid_predictor_tb;
	import igp_pkg::*;

	localparam logic [2:0] AddrMargin = 3'd0;
	localparam int StallLimit = 20000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [191:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	int           fail_count;
	int           pending;
	int           idle_pct;
	int           quiet_cycles = 0;
	word_t        mark_clock;

	interval_grid_predictor u_dut (.*);

	interval_grid_predictor_checker u_chk (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > StallLimit) begin
			$display("== FAIL ==");
			$finish;
		end
		m_tready <= ($urandom_range(99) >= idle_pct);
	end

	task automatic send_mark(word_t mark, word_t now);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {now, mark};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic write_margin(logic [31:0] value);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (800) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= AddrMargin;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic word_t rand64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		word_t m;
		word_t gap;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_pct = 29;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: mark at zero, single interval, zero step, extremes, wrap
		send_mark(64'd0, 64'd5);
		send_mark(64'd100, 64'd50);
		send_mark(64'd200, 64'd1000);
		send_mark(64'd300, 64'd300);
		send_mark(64'd300, 64'd400);
		send_mark(64'd300, 64'd400);
		write_margin(32'hFFFF_FFFF);
		send_mark(64'd300, 64'd400);
		send_mark(64'd350, 64'hFFFF_FFFF_FFFF_FFFF);
		send_mark(64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
		send_mark(64'd5, 64'hFFFF_FFFF_FFFF_FFF0);
		send_mark(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_mark(64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
		send_mark(64'd1, 64'd2);
		write_margin(32'd0);
		send_mark(64'hAAAA_AAAA_5555_5555, 64'h5555_5555_AAAA_AAAA);
		send_mark(64'h5555_5555_AAAA_AAAA, 64'hAAAA_AAAA_5555_5555);
		send_mark(64'd0, 64'd0);
		send_mark(64'd0, 64'd0);
		send_mark(64'd7, 64'd9);

		// random: mostly jittered periodic marks, some noise
		m = 64'd1000;
		for (int n = 0; n < 1000; n++) begin
			if (n % 250 == 0)
				write_margin((n == 500) ? 32'hFFFF_FFFF : $urandom);
			idle_pct = (n >= 400 && n < 550) ? 0 : 29;
			case ($urandom_range(9))
				0: m = rand64();
				1: m = 64'd0;
				2: m = m + $urandom_range(3);
				default: begin
					gap = (n % 3 == 0) ? 64'd1_000_000 : 64'd16_666;
					m = m + gap + $urandom_range(200) - 100;
				end
			endcase
			case ($urandom_range(4))
				0: send_mark(m, rand64());
				1: send_mark(m, m - $urandom_range(1000));
				default: send_mark(m, m + {$urandom_range(255), $urandom});
			endcase
		end
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
